FILE: rtl/command_line_argument_splitter_core_macros.svh
// Assertion macros used by the splitter checker.
`ifndef COMMAND_LINE_ARGUMENT_SPLITTER_CORE_MACROS_SVH
`define COMMAND_LINE_ARGUMENT_SPLITTER_CORE_MACROS_SVH

// A signal holds its value while a valid word waits for ready.
`define CLAS_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> $stable(sig)) else $error("stalled output changed");

// Whenever the antecedent is true the consequent must be true in the same cycle.
`define CLAS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error("output word breaks the format");

`endif

FILE: rtl/clas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clas_pkg;

  // Code units with a special meaning.
  localparam logic [15:0] UNIT_QUOTE  = 16'h0022;
  localparam logic [15:0] UNIT_BSLASH = 16'h005C;
  localparam logic [15:0] UNIT_SPACE  = 16'h0020;
  localparam logic [15:0] UNIT_TAB    = 16'h0009;
  localparam logic [15:0] UNIT_NUL    = 16'h0000;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_END_ARG  = 2'd1;
  localparam logic [1:0] KIND_END_LINE = 2'd2;

  // Parser phases; the unused code behaves as between arguments.
  localparam logic [1:0] PH_NAME = 2'd0;
  localparam logic [1:0] PH_GAP  = 2'd1;
  localparam logic [1:0] PH_ARG  = 2'd2;

  localparam logic [5:0] BS_RUN_MAX      = 6'd62;
  localparam logic [7:0] ARG_TOTAL_RESET = 8'd1;
  localparam logic [7:0] ARG_TOTAL_MAX   = 8'd255;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // One command: a run of backslashes, an optional tail word, an optional line end and the argument number.
  typedef struct packed {
    logic [5:0]  nbs;
    logic        t0;
    logic [15:0] t0_unit;
    logic [1:0]  t0_kind;
    logic        t1;
    logic [7:0]  argn;
  } clas_cmd_t;

  function automatic logic is_blank(input logic [15:0] c);
    return (c == UNIT_SPACE) || (c == UNIT_TAB);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/clas_front.sv
`timescale 1ns / 1ps
`default_nettype none

module clas_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [15:0]        unit_i,
  output clas_pkg::clas_cmd_t     cmd_o,
  output logic                    push_o
);

  logic [1:0] phase_q, phase_d;
  logic       quoted_q, quoted_d;
  logic       qpend_q, qpend_d;
  logic [5:0] bsrun_q, bsrun_d;
  logic [7:0] argtot_q, argtot_d;
  clas_pkg::clas_cmd_t cmd;

  // Classify the word and work out the next parser state and the command.
  always_comb begin
    logic       run_arg;
    logic       skip;
    logic       do_reset;
    logic [5:0] n;
    phase_d  = phase_q;
    quoted_d = quoted_q;
    qpend_d  = qpend_q;
    bsrun_d  = bsrun_q;
    argtot_d = argtot_q;
    run_arg  = 1'b0;
    skip     = 1'b0;
    do_reset = 1'b0;
    n        = 6'd0;
    cmd      = '0;
    cmd.t0_kind = clas_pkg::KIND_CHAR;

    if (phase_q == clas_pkg::PH_NAME) begin
      if (unit_i == clas_pkg::UNIT_QUOTE) begin
        quoted_d = ~quoted_q;
      end else if (unit_i == clas_pkg::UNIT_NUL) begin
        cmd.t0      = 1'b1;
        cmd.t0_kind = clas_pkg::KIND_END_ARG;
        cmd.t1      = 1'b1;
        do_reset    = 1'b1;
      end else if (!quoted_q && clas_pkg::is_blank(unit_i)) begin
        cmd.t0      = 1'b1;
        cmd.t0_kind = clas_pkg::KIND_END_ARG;
        quoted_d    = 1'b0;
        phase_d     = clas_pkg::PH_GAP;
      end else begin
        cmd.t0      = 1'b1;
        cmd.t0_unit = unit_i;
      end
    end else if (phase_q == clas_pkg::PH_ARG) begin
      run_arg = 1'b1;
    end else begin
      if (unit_i == clas_pkg::UNIT_NUL) begin
        cmd.t1   = 1'b1;
        do_reset = 1'b1;
      end else if (!clas_pkg::is_blank(unit_i)) begin
        if (argtot_q != clas_pkg::ARG_TOTAL_MAX) begin
          argtot_d = argtot_q + 8'd1;
        end
        phase_d  = clas_pkg::PH_ARG;
        quoted_d = 1'b0;
        qpend_d  = 1'b0;
        bsrun_d  = 6'd0;
        run_arg  = 1'b1;
      end
    end

    // Argument body: pending quote, backslash runs and quoting.
    if (run_arg) begin
      if (qpend_d) begin
        qpend_d = 1'b0;
        if (unit_i == clas_pkg::UNIT_QUOTE) begin
          cmd.t0      = 1'b1;
          cmd.t0_unit = clas_pkg::UNIT_QUOTE;
          skip        = 1'b1;
        end else begin
          quoted_d = 1'b0;
        end
      end
      if (!skip) begin
        if (unit_i == clas_pkg::UNIT_BSLASH) begin
          if (bsrun_d < clas_pkg::BS_RUN_MAX) begin
            bsrun_d = bsrun_d + 6'd1;
          end
        end else begin
          n       = bsrun_d;
          bsrun_d = 6'd0;
          if (unit_i == clas_pkg::UNIT_QUOTE) begin
            cmd.nbs = n >> 1;
            if (n[0]) begin
              cmd.t0      = 1'b1;
              cmd.t0_unit = clas_pkg::UNIT_QUOTE;
            end else if (quoted_d) begin
              qpend_d = 1'b1;
            end else begin
              quoted_d = 1'b1;
            end
          end else begin
            cmd.nbs = n;
            if (unit_i == clas_pkg::UNIT_NUL) begin
              cmd.t0      = 1'b1;
              cmd.t0_kind = clas_pkg::KIND_END_ARG;
              cmd.t1      = 1'b1;
              do_reset    = 1'b1;
            end else if (!quoted_d && clas_pkg::is_blank(unit_i)) begin
              cmd.t0      = 1'b1;
              cmd.t0_kind = clas_pkg::KIND_END_ARG;
              phase_d     = clas_pkg::PH_GAP;
            end else begin
              cmd.t0      = 1'b1;
              cmd.t0_unit = unit_i;
            end
          end
        end
      end
    end

    // Every word of one input carries the count as it stands before a line end.
    cmd.argn = argtot_d;
    if (do_reset) begin
      phase_d  = clas_pkg::PH_NAME;
      quoted_d = 1'b0;
      qpend_d  = 1'b0;
      bsrun_d  = 6'd0;
      argtot_d = clas_pkg::ARG_TOTAL_RESET;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept_i && ((cmd.nbs != 6'd0) || cmd.t0 || cmd.t1);

  // Parser state advances only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= clas_pkg::PH_NAME;
      quoted_q <= 1'b0;
      qpend_q  <= 1'b0;
      bsrun_q  <= 6'd0;
      argtot_q <= clas_pkg::ARG_TOTAL_RESET;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      quoted_q <= quoted_d;
      qpend_q  <= qpend_d;
      bsrun_q  <= bsrun_d;
      argtot_q <= argtot_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clas_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module clas_queue #(
  parameter int Depth = clas_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire clas_pkg::clas_cmd_t  push_cmd_i,
  output logic                      ready_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output clas_pkg::clas_cmd_t       head_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  clas_pkg::clas_cmd_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Storage is written in place; no reset needed for the payload.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clas_back.sv
`timescale 1ns / 1ps
`default_nettype none

module clas_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire clas_pkg::clas_cmd_t cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [15:0]            out_unit_o,
  output logic [1:0]             kind_o,
  output logic [7:0]             arg_number_o,
  output logic                   last_o
);

  logic [5:0]  pos_q;
  logic        ovalid_q;
  logic [15:0] ounit_q;
  logic [1:0]  okind_q;
  logic [7:0]  oargn_q;
  logic        olast_q;
  logic [6:0]  total;
  logic [15:0] cur_unit;
  logic [1:0]  cur_kind;
  logic        cur_last;
  logic        load;

  // Select the word at the current position of the head command.
  always_comb begin
    total = {1'b0, cmd_i.nbs} + {6'd0, cmd_i.t0} + {6'd0, cmd_i.t1};
    if (pos_q < cmd_i.nbs) begin
      cur_unit = clas_pkg::UNIT_BSLASH;
      cur_kind = clas_pkg::KIND_CHAR;
    end else if ((pos_q == cmd_i.nbs) && cmd_i.t0) begin
      cur_unit = (cmd_i.t0_kind == clas_pkg::KIND_CHAR) ? cmd_i.t0_unit : clas_pkg::UNIT_NUL;
      cur_kind = cmd_i.t0_kind;
    end else begin
      cur_unit = clas_pkg::UNIT_NUL;
      cur_kind = clas_pkg::KIND_END_LINE;
    end
    cur_last = (({1'b0, pos_q} + 7'd1) == total);
  end

  assign load      = cmd_valid_i && (!ovalid_q || out_ready_i);
  assign cmd_pop_o = load && cur_last;

  // Position within the head command, and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 6'd0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        pos_q <= cur_last ? 6'd0 : pos_q + 6'd1;
      end
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      ounit_q <= cur_unit;
      okind_q <= cur_kind;
      oargn_q <= cmd_i.argn;
      olast_q <= cur_last;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_unit_o   = ounit_q;
  assign kind_o       = okind_q;
  assign arg_number_o = oargn_q;
  assign last_o       = olast_q;

endmodule

`default_nettype wire

FILE: rtl/command_line_argument_splitter_core.sv
// Path: a word that yields results is queued as a command, and the back end then
// registers its first result in the output register, where the receiver takes it.
// Throughput: one input word per cycle, and one result word per cycle while the receiver
// is ready; an input that yields k results holds the output side until all k are sent,
// and input stalls only when the QueueDepth-entry command queue fills, e.g. while a backslash run flushes.
// Reset: rst_ni is asynchronous and active low; it returns the parser to the program
// name phase with one argument counted, empties the queue and drops output valid.
`timescale 1ns / 1ps
`default_nettype none

module command_line_argument_splitter_core #(
  parameter int QueueDepth = clas_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] out_unit, [23:16] arg_number
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser    // [1:0] kind
);

  clas_pkg::clas_cmd_t front_cmd, head_cmd;
  logic front_push, q_ready, q_valid, q_pop, accept;
  logic [15:0] out_unit;
  logic [7:0]  arg_number;

  assign s_axis_tready = q_ready;
  assign accept        = s_axis_tvalid && q_ready;

  // Front: parse each input word into a command.
  clas_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .unit_i   (s_axis_tdata),
    .cmd_o    (front_cmd),
    .push_o   (front_push)
  );

  // Command queue between front and back.
  clas_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_push),
    .push_cmd_i (front_cmd),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  // Back: expand each command into result words.
  clas_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (head_cmd),
    .cmd_pop_o    (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_unit_o   (out_unit),
    .kind_o       (m_axis_tuser),
    .arg_number_o (arg_number),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {arg_number, out_unit};

endmodule

`default_nettype wire

FILE: rtl/clas_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "command_line_argument_splitter_core_macros.svh"

module clas_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [1:0]  m_axis_tuser
);

  logic out_mark;
  logic out_eol;

  // Valid output words that are marks, and those that end the line.
  assign out_mark = m_axis_tvalid && (m_axis_tuser != clas_pkg::KIND_CHAR);
  assign out_eol  = m_axis_tvalid && (m_axis_tuser == clas_pkg::KIND_END_LINE);

  // A stalled output word keeps its valid and its contents.
  `CLAS_ASSERT_HOLD(a_valid_hold, m_axis_tvalid, m_axis_tready, m_axis_tvalid)
  `CLAS_ASSERT_HOLD(a_data_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata)

  // The unused kind code never appears.
  `CLAS_ASSERT_IMPL(a_kind_legal, m_axis_tvalid, m_axis_tuser <= clas_pkg::KIND_END_LINE)

  // Marks carry no code unit.
  `CLAS_ASSERT_IMPL(a_mark_zero, out_mark, m_axis_tdata[15:0] == clas_pkg::UNIT_NUL)

  // A line end is always the final word of its input.
  `CLAS_ASSERT_IMPL(a_eol_last, out_eol, m_axis_tlast)

endmodule

bind command_line_argument_splitter_core clas_checker u_clas_checker (.*);

`default_nettype wire
